[hw/rtl/assert_macros.svh]
// Assertion macros used by the decoder's tree walker (hbd_walk).
// Expects signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every clock, masked during reset.
`define HBD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent implies consequent on the next clock.
`define HBD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/hbd_pkg.sv]
// Shared types and constants for the Huffman bitstream decoder.
// No dependencies.
package hbd_pkg;

	localparam int SYMBOLS      = 128;
	localparam int TABLE_DEPTH  = 127;
	localparam int NODE_W       = 7;
	localparam int CODE_W       = 8;
	localparam int ENTRY_W      = 2 * CODE_W;
	localparam int BITS_W       = 32;
	localparam int CNT_W        = 4;
	localparam int BYTE_BITS    = 8;

	localparam logic [CODE_W-1:0] LEAF_MAX  = CODE_W'(SYMBOLS);
	localparam logic [CODE_W:0]   ROOT_CODE = (CODE_W + 1)'(2 * SYMBOLS - 1);
	localparam logic [NODE_W-1:0] ROOT_NODE = '0;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_START = 2'd1,
		ACT_DATA  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} walk_state_t;

	typedef struct packed {
		logic                en;
		logic [NODE_W-1:0]   addr;
		logic [ENTRY_W-1:0]  data;
	} ram_wr_t;

	typedef struct packed {
		logic               valid;
		logic [NODE_W-1:0]  symbol;
		logic               last;
	} emit_t;

endpackage

[hw/rtl/hbd_if.sv]
// Channel interfaces of the Huffman bitstream decoder: items, symbols, config.
// Depends on hbd_pkg.
interface hbd_in_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     action;
	logic [hbd_pkg::NODE_W-1:0]     node_index;
	logic [hbd_pkg::CODE_W-1:0]     left_child;
	logic [hbd_pkg::CODE_W-1:0]     right_child;
	logic [hbd_pkg::BYTE_BITS-1:0]  data_byte;

	modport source (output valid, action, node_index, left_child, right_child, data_byte,
		input ready);
	modport sink (input valid, action, node_index, left_child, right_child, data_byte,
		output ready);
endinterface

interface hbd_out_if;
	logic                        valid;
	logic                        ready;
	logic [hbd_pkg::NODE_W-1:0]  symbol;
	logic                        last;

	modport source (output valid, symbol, last, input ready);
	modport sink (input valid, symbol, last, output ready);
endinterface

interface hbd_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [hbd_pkg::BITS_W-1:0]  total_bits;

	modport source (output valid, total_bits, input ready);
	modport sink (input valid, total_bits, output ready);
endinterface

[hw/rtl/hbd_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module hbd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 127
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/hbd_walk.sv]
// Tree walker: takes input beats, writes the node table, walks data bytes bit by bit.
// Depends on hbd_pkg, hbd_if, assert_macros.svh.
`include "assert_macros.svh"

module hbd_walk (
	input  logic                        clk,
	input  logic                        arst_n,
	hbd_in_if.sink                      items,
	input  logic [hbd_pkg::BITS_W-1:0]  total_bits,
	output hbd_pkg::ram_wr_t            ram_wr,
	output logic [hbd_pkg::NODE_W-1:0]  rd_addr,
	input  logic [hbd_pkg::ENTRY_W-1:0] rd_data,
	output hbd_pkg::emit_t              push,
	input  logic                        push_ok
);

	hbd_pkg::walk_state_t state_q, state_nx;

	logic [hbd_pkg::NODE_W-1:0]    walk_node_q;
	logic [hbd_pkg::BITS_W-1:0]    bits_left_q;
	logic [hbd_pkg::CNT_W-1:0]     cnt_q;
	logic [hbd_pkg::BYTE_BITS-1:0] byte_q;
	logic                          pend_valid_q;
	logic [hbd_pkg::NODE_W-1:0]    pend_sym_q;

	logic                          accept;
	hbd_pkg::action_t              act;
	logic [hbd_pkg::CNT_W-1:0]     use_bits;
	logic [hbd_pkg::CODE_W-1:0]    code;
	logic                          is_leaf;
	logic [hbd_pkg::CODE_W:0]      target;
	logic                          ptr_ok;
	logic [hbd_pkg::NODE_W-1:0]    next_node;
	logic                          step;

	assign accept = items.valid && items.ready;
	assign act    = hbd_pkg::action_t'(items.action);

	assign use_bits = (bits_left_q < hbd_pkg::BITS_W'(hbd_pkg::BYTE_BITS))
		? bits_left_q[hbd_pkg::CNT_W-1:0] : hbd_pkg::CNT_W'(hbd_pkg::BYTE_BITS);

	// current bit selects the child out of the entry read last cycle
	assign code    = byte_q[hbd_pkg::BYTE_BITS-1]
		? rd_data[hbd_pkg::CODE_W-1:0] : rd_data[hbd_pkg::ENTRY_W-1:hbd_pkg::CODE_W];
	assign is_leaf = code <= hbd_pkg::LEAF_MAX;
	assign target  = hbd_pkg::ROOT_CODE - {1'b0, code};
	assign ptr_ok  = !target[hbd_pkg::CODE_W]
		&& (target[hbd_pkg::CODE_W-1:0] < hbd_pkg::CODE_W'(hbd_pkg::TABLE_DEPTH));
	assign next_node = (is_leaf || !ptr_ok) ? hbd_pkg::ROOT_NODE
		: target[hbd_pkg::NODE_W-1:0];

	// a second leaf needs the held one out first
	assign step = (state_q == hbd_pkg::ST_WALK) && !(is_leaf && pend_valid_q && !push_ok);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			hbd_pkg::ST_IDLE: begin
				if (accept && act == hbd_pkg::ACT_DATA && use_bits != '0) begin
					state_nx = hbd_pkg::ST_WALK;
				end
			end
			hbd_pkg::ST_WALK: begin
				if (step && cnt_q == hbd_pkg::CNT_W'(1)) begin
					state_nx = hbd_pkg::ST_FLUSH;
				end
			end
			hbd_pkg::ST_FLUSH: begin
				if (!pend_valid_q || push_ok) begin
					state_nx = hbd_pkg::ST_IDLE;
				end
			end
			default: state_nx = hbd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		items.ready = 1'b0;
		push        = '0;
		rd_addr     = walk_node_q;
		ram_wr.en   = 1'b0;
		ram_wr.addr = items.node_index;
		ram_wr.data = {items.left_child, items.right_child};
		case (state_q)
			hbd_pkg::ST_IDLE: begin
				items.ready = 1'b1;
				ram_wr.en   = accept && act == hbd_pkg::ACT_LOAD
					&& items.node_index < hbd_pkg::NODE_W'(hbd_pkg::TABLE_DEPTH);
			end
			hbd_pkg::ST_WALK: begin
				push.valid  = step && is_leaf && pend_valid_q;
				push.symbol = pend_sym_q;
				push.last   = 1'b0;
				if (step) begin
					rd_addr = next_node;
				end
			end
			hbd_pkg::ST_FLUSH: begin
				push.valid  = pend_valid_q && push_ok;
				push.symbol = pend_sym_q;
				push.last   = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= hbd_pkg::ST_IDLE;
			walk_node_q  <= hbd_pkg::ROOT_NODE;
			bits_left_q  <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == hbd_pkg::ST_IDLE && accept) begin
				if (act == hbd_pkg::ACT_START) begin
					walk_node_q <= hbd_pkg::ROOT_NODE;
					bits_left_q <= total_bits;
				end else if (act == hbd_pkg::ACT_DATA) begin
					bits_left_q <= bits_left_q - {{(hbd_pkg::BITS_W-hbd_pkg::CNT_W){1'b0}},
						use_bits};
					cnt_q       <= use_bits;
				end
			end
			if (step) begin
				walk_node_q <= next_node;
				cnt_q       <= cnt_q - hbd_pkg::CNT_W'(1);
				if (is_leaf) begin
					pend_valid_q <= 1'b1;
				end
			end
			if (state_q == hbd_pkg::ST_FLUSH && push_ok) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == hbd_pkg::ST_IDLE && accept && act == hbd_pkg::ACT_DATA) begin
			byte_q <= items.data_byte;
		end else if (step) begin
			byte_q <= {byte_q[hbd_pkg::BYTE_BITS-2:0], 1'b0};
		end
		if (step && is_leaf) begin
			pend_sym_q <= code[hbd_pkg::NODE_W-1:0] - hbd_pkg::NODE_W'(1);
		end
	end

	`HBD_ASSERT(a_node_range, walk_node_q < hbd_pkg::NODE_W'(hbd_pkg::TABLE_DEPTH), "walk node out of table")
	`HBD_ASSERT(a_walk_cnt, state_q != hbd_pkg::ST_WALK || cnt_q != '0, "walking with no bits")
	`HBD_ASSERT(a_idle_empty, state_q != hbd_pkg::ST_IDLE || !pend_valid_q, "symbol held while idle")
	`HBD_ASSERT(a_push_busy, !push.valid || state_q != hbd_pkg::ST_IDLE, "emit while idle")
	`HBD_ASSERT_NEXT(a_flush_done, state_q == hbd_pkg::ST_FLUSH && !pend_valid_q, state_q == hbd_pkg::ST_IDLE, "flush did not finish")

endmodule

[hw/rtl/huffman_bitstream_decoder.sv]
// Huffman bitstream decoder. Load and start beats, and bytes with no bits left, are taken without leaving idle.
// A byte using n bits is walked with one node-table read per bit, then a flush state sends its last symbol:
// ready stays low through the walk and the flush, so the next beat is taken only back in idle,
// and a stall on symbol output can hold both the walk and the flush.
// Reset clears walk position, bit budget, total_bits and output valid; the node table is
// undefined until loaded and gets no clearing pass.
module huffman_bitstream_decoder (
	input  logic       clk,
	input  logic       arst_n,
	hbd_in_if.sink     items,
	hbd_out_if.source  symbols,
	hbd_cfg_if.sink    cfg
);

	logic [hbd_pkg::BITS_W-1:0]  total_bits_q;
	hbd_pkg::ram_wr_t            ram_wr;
	logic [hbd_pkg::NODE_W-1:0]  rd_addr;
	logic [hbd_pkg::ENTRY_W-1:0] rd_data;
	hbd_pkg::emit_t              push;
	logic                        push_ok;
	logic                        out_valid_q;
	logic [hbd_pkg::NODE_W-1:0]  out_sym_q;
	logic                        out_last_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_bits_q <= '0;
		end else if (cfg.valid) begin
			total_bits_q <= cfg.total_bits;
		end
	end

	hbd_ram #(
		.WIDTH (hbd_pkg::ENTRY_W),
		.DEPTH (hbd_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_wr.en),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	hbd_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.total_bits (total_bits_q),
		.ram_wr     (ram_wr),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.push       (push),
		.push_ok    (push_ok)
	);

	assign push_ok = !out_valid_q || symbols.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push.valid) begin
			out_valid_q <= 1'b1;
		end else if (symbols.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			out_sym_q  <= push.symbol;
			out_last_q <= push.last;
		end
	end

	assign symbols.valid  = out_valid_q;
	assign symbols.symbol = out_sym_q;
	assign symbols.last   = out_last_q;

endmodule

[test/tb_top.sv]
// Self-checking bench for the Huffman bitstream decoder: loads node tables, runs
// bit-budgeted streams and checks every decoded symbol against an in-bench decoder.
// Depends on hbd_pkg, the hbd_if channel interfaces and huffman_bitstream_decoder.
`timescale 1ns / 1ps

module tb_top;
	import hbd_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_GAP    = 20;
	localparam int TAIL_CYCLES = 30;

	typedef struct packed {
		action_t               action;
		logic [NODE_W-1:0]     node_index;
		logic [CODE_W-1:0]     left_child;
		logic [CODE_W-1:0]     right_child;
		logic [BYTE_BITS-1:0]  data_byte;
	} item_t;

	typedef struct packed {
		logic [NODE_W-1:0]  symbol;
		logic               last;
	} sym_t;

	logic clk;
	logic arst_n = 1'b0;

	hbd_in_if  item_bus();
	hbd_out_if sym_bus();
	hbd_cfg_if cfg_bus();

	huffman_bitstream_decoder uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_bus),
		.symbols (sym_bus),
		.cfg     (cfg_bus)
	);

	// Bench-side drive registers
	logic               in_valid  = 1'b0;
	item_t              drv_item  = '0;
	logic               rx_ready  = 1'b0;
	logic               rx_hold   = 1'b0;
	logic               cfg_valid = 1'b0;
	logic [BITS_W-1:0]  cfg_data  = '0;

	assign item_bus.valid       = in_valid;
	assign item_bus.action      = drv_item.action;
	assign item_bus.node_index  = drv_item.node_index;
	assign item_bus.left_child  = drv_item.left_child;
	assign item_bus.right_child = drv_item.right_child;
	assign item_bus.data_byte   = drv_item.data_byte;
	assign sym_bus.ready        = rx_ready;
	assign cfg_bus.valid        = cfg_valid;
	assign cfg_bus.total_bits   = cfg_data;

	// Decoder state as the bench sees it
	logic [ENTRY_W-1:0]  tree_mem [TABLE_DEPTH];
	logic [NODE_W-1:0]   walk_pos       = ROOT_NODE;
	logic [BITS_W-1:0]   bits_remaining = '0;
	logic [BITS_W-1:0]   budget_reg     = '0;
	sym_t                decoded_syms [$];

	// Stimulus bookkeeping
	item_t  item_fifo [$];
	bit     tree_known [TABLE_DEPTH];
	int     known_nodes [$];
	int     items_queued = 0;
	int     items_taken  = 0;
	int     fail_count   = 0;
	int     tx_gap       = 0;
	int     rx_stall     = 0;
	bit     quiet        = 1'b0;
	bit     hold_go      = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400_000;
		$display("TB_ERROR");
		$finish;
	end

	// Apply one accepted item: load a node, restart, or walk a byte through the node table and queue the symbols it yields
	function automatic void decode_item(input item_t it);
		sym_t         out_syms [BYTE_BITS];
		int           n_out;
		int           n_use;
		int           target;
		int           i;
		logic [15:0]  entry;
		logic [7:0]   code;
		n_out = 0;
		case (it.action)
			ACT_LOAD: begin
				if (it.node_index < TABLE_DEPTH)
					tree_mem[it.node_index] = {it.left_child, it.right_child};
			end
			ACT_START: begin
				walk_pos = ROOT_NODE;
				bits_remaining = budget_reg;
			end
			ACT_DATA: begin
				n_use = (bits_remaining < BYTE_BITS) ? int'(bits_remaining) : BYTE_BITS;
				bits_remaining = bits_remaining - BITS_W'(n_use);
				for (i = 0; i < n_use; i++) begin
					entry = tree_mem[walk_pos];
					code = it.data_byte[BYTE_BITS-1-i] ? entry[CODE_W-1:0] : entry[ENTRY_W-1:CODE_W];
					if (code <= LEAF_MAX) begin
						// leaf code zero wraps to the top symbol
						out_syms[n_out].symbol = NODE_W'(code - 8'd1);
						out_syms[n_out].last = 1'b0;
						n_out++;
						walk_pos = ROOT_NODE;
					end else begin
						target = 2 * SYMBOLS - 1 - int'(code);
						if (target < 0 || target >= TABLE_DEPTH)
							walk_pos = ROOT_NODE;
						else
							walk_pos = NODE_W'(target);
					end
				end
				if (n_out > 0)
					out_syms[n_out-1].last = 1'b1;
				for (i = 0; i < n_out; i++)
					decoded_syms.push_back(out_syms[i]);
			end
			default: ;
		endcase
	endfunction

	function automatic item_t noise_item(input action_t a);
		item_t it;
		it.action      = a;
		it.node_index  = NODE_W'($urandom);
		it.left_child  = CODE_W'($urandom);
		it.right_child = CODE_W'($urandom);
		it.data_byte   = BYTE_BITS'($urandom);
		return it;
	endfunction

	// Leaf, or pointer to an entry already queued for loading, so no walk hits an unwritten entry
	function automatic int pick_child();
		if (known_nodes.size() == 0 || $urandom_range(0, 9) < 4)
			return $urandom_range(0, SYMBOLS);
		return 2 * SYMBOLS - 1 - known_nodes[$urandom_range(0, known_nodes.size() - 1)];
	endfunction

	function automatic void queue_item(input item_t it);
		item_fifo.push_back(it);
		items_queued++;
	endfunction

	// lc/rc below zero pick a random child
	function automatic void queue_load(input int idx, input int lc, input int rc);
		item_t it;
		it = noise_item(ACT_LOAD);
		it.node_index = NODE_W'(idx);
		if (idx < TABLE_DEPTH && !tree_known[idx]) begin
			tree_known[idx] = 1'b1;
			known_nodes.push_back(idx);
		end
		it.left_child  = CODE_W'((lc < 0) ? pick_child() : lc);
		it.right_child = CODE_W'((rc < 0) ? pick_child() : rc);
		queue_item(it);
	endfunction

	function automatic void queue_op(input action_t a, input int data);
		item_t it;
		it = noise_item(a);
		if (data >= 0)
			it.data_byte = BYTE_BITS'(data);
		queue_item(it);
	endfunction

	// Mostly start-then-bytes streams, with reloads, restarts and dead beats mixed in
	function automatic void queue_random_stream(input int n_items);
		int count;
		int r;
		queue_op(ACT_START, -1);
		count = 1;
		while (count < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 62) begin
				queue_op(ACT_DATA, -1);
				count++;
			end else if (r < 77) begin
				queue_load($urandom_range(0, TABLE_DEPTH - 1), -1, -1);
				count++;
			end else if (r < 85) begin
				queue_op(ACT_START, -1);
				count++;
			end else if (r < 92) begin
				queue_op(ACT_NONE, -1);
			end else begin
				queue_load(TABLE_DEPTH, -1, -1);
			end
		end
	endfunction

	task automatic wait_drained();
		while (items_taken != items_queued || decoded_syms.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_total_bits(input logic [BITS_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		cfg_valid <= 1'b0;
		budget_reg = value;
	endtask

	task automatic next_phase(input logic [BITS_W-1:0] value);
		wait_drained();
		// loads and empty bytes yield nothing, let the block settle
		repeat (IDLE_GAP) @(posedge clk);
		write_total_bits(value);
	endtask

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		write_total_bits('0);

		// zero budget: bytes before and after start decode nothing
		queue_op(ACT_DATA, 8'hFF);
		queue_load(TABLE_DEPTH - 1, 0, SYMBOLS);
		queue_load(1, 1, 2 * SYMBOLS - 1);
		queue_load(0, 2 * SYMBOLS - 2, SYMBOLS + 1);
		queue_load(TABLE_DEPTH, 8'h55, 8'hAA);
		queue_op(ACT_START, -1);
		queue_op(ACT_DATA, 8'hA5);
		queue_op(ACT_NONE, -1);

		next_phase('1);
		queue_op(ACT_START, -1);
		queue_op(ACT_DATA, 8'h00);
		queue_op(ACT_DATA, 8'hFF);
		queue_op(ACT_DATA, 8'h96);
		queue_op(ACT_NONE, -1);
		queue_load(2, 127, 64);
		queue_load(1, 1, 2 * SYMBOLS - 3);
		queue_op(ACT_DATA, 8'h6C);
		queue_op(ACT_DATA, 8'hFF);

		// budget runs out partway through the second byte
		next_phase(32'd13);
		queue_op(ACT_START, -1);
		queue_op(ACT_DATA, 8'hFF);
		queue_op(ACT_DATA, 8'h00);
		queue_op(ACT_DATA, 8'h5A);
		queue_op(ACT_START, -1);
		queue_op(ACT_DATA, 8'h33);

		next_phase('1);
		queue_random_stream(30);
		hold_go = 1'b1;

		next_phase(BITS_W'($urandom_range(1, 60)));
		queue_random_stream(22);

		next_phase(BITS_W'($urandom));
		queue_random_stream(22);

		next_phase('0);
		queue_random_stream(10);

		next_phase(BITS_W'($urandom_range(64, 600)));
		quiet = 1'b1;
		queue_random_stream(25);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && decoded_syms.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Long receiver hold-off so the block backs up and stalls its input
	initial begin : rx_holdoff
		while (!hold_go)
			@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk) begin : item_driver
		logic   offer;
		item_t  nxt;
		if (arst_n) begin
			offer = in_valid;
			nxt = drv_item;
			if (in_valid && item_bus.ready) begin
				decode_item(drv_item);
				items_taken++;
				offer = 1'b0;
				if (!quiet && $urandom_range(0, 4) == 0)
					tx_gap = $urandom_range(1, 5);
			end
			if (!offer) begin
				if (tx_gap > 0)
					tx_gap--;
				else if (item_fifo.size() > 0) begin
					nxt = item_fifo.pop_front();
					offer = 1'b1;
				end
			end
			in_valid <= offer;
			drv_item <= nxt;
		end
	end

	always @(posedge clk) begin : symbol_monitor
		sym_t  want;
		logic  rdy;
		if (arst_n) begin
			if (rx_ready && sym_bus.valid) begin
				if (decoded_syms.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected symbol beat, expected none, actual symbol %0d last %0b",
						$time, sym_bus.symbol, sym_bus.last);
				end else begin
					want = decoded_syms.pop_front();
					if (sym_bus.symbol !== want.symbol) begin
						fail_count++;
						$display("%0t: symbol mismatch, expected %0d, actual %0d",
							$time, want.symbol, sym_bus.symbol);
					end
					if (sym_bus.last !== want.last) begin
						fail_count++;
						$display("%0t: last mismatch, expected %0b, actual %0b",
							$time, want.last, sym_bus.last);
					end
				end
			end
			if (rx_hold)
				rdy = 1'b0;
			else if (rx_stall > 0) begin
				rx_stall--;
				rdy = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				rx_stall = $urandom_range(0, 4);
				rdy = 1'b0;
			end else
				rdy = 1'b1;
			rx_ready <= rdy;
		end
	end

endmodule
